[rtl/sfr_pkg.sv]
package sfr_pkg;

    // Register storage fixed by the register map.
    localparam int PAT_BYTES   = 16;
    localparam int REP_BYTES   = 24;
    localparam int PATTERN_DEF = 16;
    localparam int REPLACE_DEF = 24;
    localparam int CFG_AW      = 3;

    localparam logic [CFG_AW-1:0] CFG_PAT_LEN = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_PAT_LO  = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_PAT_HI  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_REP_LEN = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_REP_A   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_REP_B   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_REP_C   = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAIN,
        S_APPEND,
        S_CHECK,
        S_REPL,
        S_FLUSH
    } t_state;

    // Per-cycle control for one window cell.
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

[rtl/sfr_cell.sv]
module sfr_cell import sfr_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctl  i_ctl,
    input  logic [7:0] i_next_byte,
    input  logic [7:0] i_new_byte,
    input  logic [7:0] i_pat_byte,
    input  logic       i_in_use,
    output logic [7:0] o_byte,
    output logic       o_eq
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_new_byte;
        end else if (i_ctl.shift) begin
            r_byte <= i_next_byte;
        end
    end

    assign o_byte = r_byte;
    // Cells beyond the pattern length never block a match.
    assign o_eq   = !i_in_use || (r_byte == i_pat_byte);

endmodule

[rtl/stream_find_replace.sv]
// A byte beat passes the drain, append and check states, then the replacement bytes on a match;
// at string end without a replacement, the bytes still held are flushed, or a bare end marker
// is shown. A beat without a byte goes to the flush. Results are registered, output stalls hold
// the sequencer, and a new beat is accepted only when the sequencer is back in idle.
// Reset is synchronous and active low; it clears the sequencer, the window fill count,
// the output valid flag and all configuration registers. Window bytes are not cleared.
module stream_find_replace import sfr_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_DEF,
    parameter int REPLACE_MAX = REPLACE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,   // [7:0] char_in
    input  logic              i_s_tuser,   // [0] carries_byte
    input  logic              i_s_tlast,   // string_end
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [15:0]       o_m_tdata,   // [7:0] char_out, [8] run_last, rest zero
    output logic              o_m_tuser,   // [0] byte_valid
    output logic              o_m_tlast,   // result_end
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [63:0]       i_cfg_data
);

    localparam int FILL_W = $clog2(PATTERN_MAX + 1);
    localparam int RLEN_W = $clog2(REPLACE_MAX + 1);

    // Configuration registers.
    logic [4:0]             r_pat_len;
    logic [4:0]             r_rep_len;
    logic [8*PAT_BYTES-1:0] r_pat;
    logic [8*REP_BYTES-1:0] r_rep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_rep_len <= '0;
            r_pat     <= '0;
            r_rep     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[4:0];
                CFG_PAT_LO:  r_pat[63:0] <= i_cfg_data;
                CFG_PAT_HI:  r_pat[127:64] <= i_cfg_data;
                CFG_REP_LEN: r_rep_len <= i_cfg_data[4:0];
                CFG_REP_A:   r_rep[63:0] <= i_cfg_data;
                CFG_REP_B:   r_rep[127:64] <= i_cfg_data;
                CFG_REP_C:   r_rep[191:128] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [FILL_W-1:0] plen;
    logic [RLEN_W-1:0] rlen;

    assign plen = ({1'b0, r_pat_len} > 6'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX)
                                                         : FILL_W'(r_pat_len);
    assign rlen = ({1'b0, r_rep_len} > 6'(REPLACE_MAX)) ? RLEN_W'(REPLACE_MAX)
                                                         : RLEN_W'(r_rep_len);

    // Sequencer and captured beat.
    t_state            r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [RLEN_W-1:0] r_cnt, n_cnt;
    logic              r_drained, n_drained;
    logic              r_emitted, n_emitted;
    logic [7:0]        r_char;
    logic              r_end;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_bv;
    logic       r_out_end;
    logic       r_out_last;

    logic       s_accept;
    logic       out_free;
    logic       emit;
    logic [7:0] e_char;
    logic       e_bv;
    logic       e_last;
    logic       pop;
    logic       append;
    logic       hit;
    logic [7:0] rep_byte;

    logic [7:0]             cell_byte [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq_vec;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign hit      = &eq_vec;
    assign rep_byte = (int'(r_cnt) < REP_BYTES) ? r_rep[8*int'(r_cnt) +: 8] : 8'h00;

    // Window: a chain of cells, oldest byte in cell 0, shifting toward it on a pop.
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        t_cell_ctl  ctl;
        logic [7:0] next_byte;
        logic [7:0] pat_byte;

        assign ctl.shift = pop;
        assign ctl.load  = append && (r_fill == FILL_W'(k));

        if (k + 1 < PATTERN_MAX) begin : g_mid
            assign next_byte = cell_byte[k+1];
        end else begin : g_end
            assign next_byte = 8'h00;
        end

        if (k < PAT_BYTES) begin : g_pat
            assign pat_byte = r_pat[8*k +: 8];
        end else begin : g_zero
            assign pat_byte = 8'h00;
        end

        sfr_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_next_byte (next_byte),
            .i_new_byte  (r_char),
            .i_pat_byte  (pat_byte),
            .i_in_use    (32'(plen) > k),
            .o_byte      (cell_byte[k]),
            .o_eq        (eq_vec[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_drained <= 1'b0;
            r_emitted <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_drained <= n_drained;
            r_emitted <= n_emitted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_char <= i_s_tdata;
            r_end  <= i_s_tlast;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_drained = r_drained;
        n_emitted = r_emitted;
        emit      = 1'b0;
        e_char    = cell_byte[0];
        e_bv      = 1'b1;
        e_last    = 1'b0;
        pop       = 1'b0;
        append    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_state   = i_s_tuser ? S_DRAIN : S_FLUSH;
                    n_drained = 1'b0;
                    n_emitted = 1'b0;
                end
            end
            S_DRAIN: begin
                // A stale window gives up its oldest byte first; more always follows.
                if (r_fill != '0 && r_fill >= plen) begin
                    if (out_free) begin
                        emit      = 1'b1;
                        pop       = 1'b1;
                        n_fill    = r_fill - 1'b1;
                        n_drained = 1'b1;
                        n_state   = S_APPEND;
                    end
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (32'(r_fill) < PATTERN_MAX) begin
                    append = 1'b1;
                    n_fill = r_fill + 1'b1;
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_drained && plen != '0 && r_fill == plen && hit) begin
                    n_fill = '0;
                    if (rlen != '0) begin
                        n_cnt   = '0;
                        n_state = S_REPL;
                    end else begin
                        n_state = r_end ? S_FLUSH : S_IDLE;
                    end
                end else if (r_fill != '0 && r_fill >= plen) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        pop     = 1'b1;
                        e_last  = !(r_end && r_fill > FILL_W'(1));
                        n_fill  = r_fill - 1'b1;
                        n_state = r_end ? S_FLUSH : S_IDLE;
                    end
                end else begin
                    n_state = r_end ? S_FLUSH : S_IDLE;
                end
            end
            S_REPL: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_char = rep_byte;
                    e_last = (r_cnt == RLEN_W'(rlen - 1'b1));
                    if (e_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_end) begin
                    n_state = S_IDLE;
                end else if (r_fill != '0) begin
                    if (out_free) begin
                        emit   = 1'b1;
                        pop    = 1'b1;
                        e_last = (r_fill == FILL_W'(1));
                        n_fill = r_fill - 1'b1;
                        if (e_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (!r_emitted) begin
                    // End of string with nothing to show: a bare end marker.
                    if (out_free) begin
                        emit    = 1'b1;
                        e_char  = 8'h00;
                        e_bv    = 1'b0;
                        e_last  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (emit) begin
            n_emitted = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= e_char;
            r_out_bv   <= e_bv;
            r_out_last <= e_last;
            r_out_end  <= e_last && r_end;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_last, r_out_char};
    assign o_m_tuser  = r_out_bv;
    assign o_m_tlast  = r_out_end;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= PATTERN_MAX)
        else $error("window fill beyond its depth");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != S_IDLE))
        else $error("sequencer did not start on an accepted beat");

    a_end_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE && r_end) |=> (r_fill == '0))
        else $error("window not empty after string end");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> o_m_tdata[8])
        else $error("string end result not marked last of its beat");

endmodule
